// ===== hdl/hlce_pkg.sv =====
`timescale 1ns / 1ps

package hlce_pkg;

  // bucket 0 holds pairs at index distance 16 or more, bucket k distance k
  localparam int NUM_BUCKETS = 16;
  localparam int BKT_W       = 4;
  localparam logic [3:0] SEP_RESET = 4'd3;
  localparam logic [7:0] HIT_MAX   = 8'd128;

  typedef struct packed {
    logic              hydrophobic;
    logic signed [7:0] x_coord;
    logic signed [7:0] y_coord;
    logic              last_residue;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] energy;
    logic              collision;
    logic              overflow;
    logic [6:0]        chain_length;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic sum;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rd_end;
    logic cmp_pend;
    logic last;
    logic sum_end;
  } dp_stat_t;

endpackage

// ===== hdl/hlce_ctrl.sv =====
`timescale 1ns / 1ps

module hlce_ctrl
  import hlce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  dp_stat_t   st,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_SUM  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!st.rd_end) begin
          cmd.rd = 1'b1;
        end else if (!st.cmp_pend) begin
          state_nxt = st.last ? S_SUM : S_IDLE;
        end
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        if (st.sum_end) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== hdl/hlce_dp.sv =====
`timescale 1ns / 1ps

module hlce_dp
  import hlce_pkg::*;
#(
  parameter int MAX_RESIDUES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  input  ctrl_cmd_t  cmd,
  output dp_stat_t   st,
  output logic       out_valid,
  output out_item_t  out_data
);

  localparam int AW = (MAX_RESIDUES > 1) ? $clog2(MAX_RESIDUES) : 1;
  localparam int CW = $clog2(MAX_RESIDUES + 1);
  localparam int DW = (CW > 5) ? CW : 5;

  // residue store
  logic signed [7:0] mem_x [MAX_RESIDUES];
  logic signed [7:0] mem_y [MAX_RESIDUES];
  logic              mem_h [MAX_RESIDUES];

  logic [3:0]        minsep_r;
  logic [CW-1:0]     cnt_r;
  logic              ovf_r;
  logic              coll_r;
  logic [7:0]        bkt_r [NUM_BUCKETS];

  logic signed [7:0] nx_r, ny_r;
  logic              nh_r;
  logic              last_r;
  logic [CW-1:0]     lim_r;
  logic [CW-1:0]     rd_idx_r;
  logic [CW-1:0]     cmp_idx_r;
  logic              rdv_r;
  logic signed [7:0] rd_x_r, rd_y_r;
  logic              rd_h_r;

  logic [7:0]        acc_r;
  logic [BKT_W-1:0]  sum_idx_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic              room;
  logic [8:0]        dx, dy;
  logic              same_site, adjacent, contact;
  logic [DW-1:0]     idx_gap;
  logic [BKT_W-1:0]  bsel;
  logic              incl;
  logic [8:0]        acc_sum;
  logic [7:0]        acc_nxt;

  assign room = (cnt_r < CW'(MAX_RESIDUES));

  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      mem_x[cnt_r[AW-1:0]] <= in_data.x_coord;
      mem_y[cnt_r[AW-1:0]] <= in_data.y_coord;
      mem_h[cnt_r[AW-1:0]] <= in_data.hydrophobic;
    end
    if (cmd.rd) begin
      rd_x_r <= mem_x[rd_idx_r[AW-1:0]];
      rd_y_r <= mem_y[rd_idx_r[AW-1:0]];
      rd_h_r <= mem_h[rd_idx_r[AW-1:0]];
    end
  end

  // compare the new residue against one stored residue
  always_comb begin
    dx        = {rd_x_r[7], rd_x_r} - {nx_r[7], nx_r};
    dy        = {rd_y_r[7], rd_y_r} - {ny_r[7], ny_r};
    same_site = (dx == 9'd0) && (dy == 9'd0);
    adjacent  = ((dx == 9'd0) && ((dy == 9'h001) || (dy == 9'h1FF))) ||
                ((dy == 9'd0) && ((dx == 9'h001) || (dx == 9'h1FF)));
    contact   = rdv_r && rd_h_r && nh_r && adjacent;
    idx_gap   = DW'(lim_r) - DW'(cmp_idx_r);
    bsel      = (idx_gap >= DW'(NUM_BUCKETS)) ? '0 : idx_gap[BKT_W-1:0];
  end

  // final pass over bucket 0 and the buckets from min_separation up, saturating at the hit limit
  always_comb begin
    incl    = (sum_idx_r == '0) || (sum_idx_r >= minsep_r);
    acc_sum = {1'b0, acc_r} + {1'b0, bkt_r[sum_idx_r]};
    if (!incl) begin
      acc_nxt = acc_r;
    end else if (acc_sum >= {1'b0, HIT_MAX}) begin
      acc_nxt = HIT_MAX;
    end else begin
      acc_nxt = acc_sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minsep_r    <= SEP_RESET;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      coll_r      <= 1'b0;
      rdv_r       <= 1'b0;
      rd_idx_r    <= '0;
      lim_r       <= '0;
      sum_idx_r   <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_BUCKETS; k++) begin
        bkt_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        minsep_r <= cfg_wdata;
      end
      rdv_r       <= cmd.rd;
      out_valid_r <= cmd.emit;

      if (cmd.load) begin
        nx_r      <= in_data.x_coord;
        ny_r      <= in_data.y_coord;
        nh_r      <= in_data.hydrophobic;
        last_r    <= in_data.last_residue;
        rd_idx_r  <= '0;
        sum_idx_r <= '0;
        acc_r     <= '0;
        if (room) begin
          lim_r <= cnt_r;
          cnt_r <= cnt_r + 1'b1;
        end else begin
          lim_r <= '0;
          ovf_r <= 1'b1;
        end
      end

      if (cmd.rd) begin
        cmp_idx_r <= rd_idx_r;
        rd_idx_r  <= rd_idx_r + 1'b1;
      end

      if (rdv_r && same_site) begin
        coll_r <= 1'b1;
      end
      if (contact && (bkt_r[bsel] < HIT_MAX)) begin
        bkt_r[bsel] <= bkt_r[bsel] + 8'd1;
      end

      if (cmd.sum) begin
        acc_r     <= acc_nxt;
        sum_idx_r <= sum_idx_r + 1'b1;
      end

      if (cmd.emit) begin
        out_r.energy       <= coll_r ? 8'sd0 : $signed(8'd0 - acc_r);
        out_r.collision    <= coll_r;
        out_r.overflow     <= ovf_r;
        out_r.chain_length <= 7'(cnt_r);
        cnt_r  <= '0;
        ovf_r  <= 1'b0;
        coll_r <= 1'b0;
        for (int k = 0; k < NUM_BUCKETS; k++) begin
          bkt_r[k] <= '0;
        end
      end
    end
  end

  assign st.rd_end   = (rd_idx_r == lim_r);
  assign st.cmp_pend = rdv_r;
  assign st.last     = last_r;
  assign st.sum_end  = (sum_idx_r == BKT_W'(NUM_BUCKETS - 1));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/hp_lattice_chain_energy_top.sv =====
`timescale 1ns / 1ps

// HP model chain scorer on a 2D square lattice.
// Residues enter one per transaction on in_data (hydrophobic bit, signed x,y,
// last_residue mark); a transaction is taken on a clock edge with start high
// and busy low. The residue marked last closes the chain and one result
// (energy, collision, overflow, chain_length) appears on out_data for exactly
// one cycle with out_valid high; the receiver cannot stall it.
// Each residue that fits is written to the store and compared against all
// earlier residues of the chain, one stored residue per cycle through the
// single read port, with busy high until that scan ends. Contacts are
// binned by index distance; the closing residue adds a pass over the bins
// and a registered result, which shows in the first cycle with busy low.
// A residue beyond MAX_RESIDUES is dropped and sets the overflow flag;
// if marked last, it still closes the chain. cfg_we/cfg_wdata set
// min_separation (reset 3) and are to be written between chains by the
// user; the block itself does not enforce this. Synchronous active-low
// reset empties the chain and clears all flags; no clearing pass is needed.
module hp_lattice_chain_energy_top
  import hlce_pkg::*;
#(
  parameter int MAX_RESIDUES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_data,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  output logic       out_valid,
  output out_item_t  out_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  st;

  hlce_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  hlce_dp #(
    .MAX_RESIDUES (MAX_RESIDUES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== verif/hlce_score_checker.sv =====
`timescale 1ns / 1ps

module hlce_score_checker
  import hlce_pkg::*;
#(
  parameter int MAX_RESIDUES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_item_t   in_data,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  input  logic       out_valid,
  input  out_item_t  out_data,
  output int         fail_count,
  output int         scores_pending,
  output int         scores_checked
);

  // private copy of the chain store
  logic signed [7:0] site_x [MAX_RESIDUES];
  logic signed [7:0] site_y [MAX_RESIDUES];
  logic              site_h [MAX_RESIDUES];
  int                chain_cnt;
  logic              dropped;
  logic [3:0]        min_sep;

  out_item_t expected_scores [$];
  int        n_fail;
  int        n_checked;

  initial begin
    n_fail    = 0;
    n_checked = 0;
  end

  function automatic out_item_t score_chain();
    int        hits;
    int        manhattan;
    logic      clash;
    out_item_t r;
    hits  = 0;
    clash = 1'b0;
    for (int i = 0; i < chain_cnt; i++)
      for (int j = i + 1; j < chain_cnt; j++)
        if (site_x[i] == site_x[j] && site_y[i] == site_y[j])
          clash = 1'b1;
    if (!clash) begin
      for (int i = 0; i < chain_cnt; i++) begin
        if (!site_h[i])
          continue;
        for (int j = i + 1; j < chain_cnt; j++) begin
          if (!site_h[j] || (j - i) < int'(min_sep))
            continue;
          // sign-extended distance, so 127 and -128 are far apart
          manhattan = (site_x[i] > site_x[j]) ? int'(site_x[i]) - int'(site_x[j])
                                              : int'(site_x[j]) - int'(site_x[i]);
          manhattan += (site_y[i] > site_y[j]) ? int'(site_y[i]) - int'(site_y[j])
                                               : int'(site_y[j]) - int'(site_y[i]);
          if (manhattan == 1 && hits < int'(HIT_MAX))
            hits++;
        end
      end
    end
    r.energy       = 8'(-hits);
    r.collision    = clash;
    r.overflow     = dropped;
    r.chain_length = 7'(chain_cnt);
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      chain_cnt = 0;
      dropped   = 1'b0;
      min_sep   = SEP_RESET;
      expected_scores.delete();
    end else begin
      if (out_valid) begin
        if (expected_scores.size() == 0) begin
          n_fail++;
          $display("%0t: score with no closed chain, expected none, got %p",
                   $time, out_data);
        end else begin
          want = expected_scores.pop_front();
          check_field("energy", 32'(want.energy), 32'(out_data.energy));
          check_field("collision", 32'(want.collision), 32'(out_data.collision));
          check_field("overflow", 32'(want.overflow), 32'(out_data.overflow));
          check_field("chain_length", 32'(want.chain_length),
                      32'(out_data.chain_length));
          n_checked++;
        end
      end
      if (cfg_we)
        min_sep = cfg_wdata;
      if (start && !busy) begin
        if (chain_cnt < MAX_RESIDUES) begin
          site_x[chain_cnt] = in_data.x_coord;
          site_y[chain_cnt] = in_data.y_coord;
          site_h[chain_cnt] = in_data.hydrophobic;
          chain_cnt++;
        end else begin
          dropped = 1'b1;
        end
        if (in_data.last_residue) begin
          expected_scores.push_back(score_chain());
          chain_cnt = 0;
          dropped   = 1'b0;
        end
      end
    end
    fail_count     <= n_fail;
    scores_pending <= expected_scores.size();
    scores_checked <= n_checked;
  end

endmodule

// ===== verif/hp_lattice_chain_energy_top_tb.sv =====
`timescale 1ns / 1ps

module hp_lattice_chain_energy_top_tb;
  import hlce_pkg::*;

  localparam int MAX_RESIDUES = 64;
  localparam int MAX_CYCLES   = 600000;
  localparam int PHASE_ITEMS  = 125;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  logic       busy;
  in_item_t   in_data   = '0;
  logic       cfg_we    = 1'b0;
  logic [3:0] cfg_wdata = '0;
  logic       out_valid;
  out_item_t  out_data;

  int fail_count;
  int scores_pending;
  int scores_checked;

  in_item_t chain_q [$];
  bit       steady;
  int       residues_sent = 0;
  int       chains_sent   = 0;
  int       sep_writes    = 0;
  int       cycles        = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  hp_lattice_chain_energy_top #(
    .MAX_RESIDUES(MAX_RESIDUES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  hlce_score_checker #(
    .MAX_RESIDUES(MAX_RESIDUES)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_data       (in_data),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .scores_pending(scores_pending),
    .scores_checked(scores_checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic bit draw_h(input int hp);
    return $urandom_range(1, 100) <= hp;
  endfunction

  function automatic void add_residue(input logic [7:0] x, input logic [7:0] y,
                                      input bit h);
    in_item_t r;
    r.hydrophobic  = h;
    r.x_coord      = x;
    r.y_coord      = y;
    r.last_residue = 1'b0;
    chain_q.push_back(r);
  endfunction

  // self-avoiding where it can be, crossing itself when eight random tries all hit occupied sites
  task automatic build_walk(input int len, input int hp);
    logic [7:0] x, y, nx, ny;
    int         tries;
    bit         occupied [logic [15:0]];
    x = 8'($urandom_range(0, 255));
    y = 8'($urandom_range(0, 255));
    for (int k = 0; k < len; k++) begin
      if (k > 0) begin
        tries = 0;
        do begin
          nx = x;
          ny = y;
          case ($urandom_range(0, 3))
            0: nx = x + 8'd1;
            1: nx = x - 8'd1;
            2: ny = y + 8'd1;
            default: ny = y - 8'd1;
          endcase
          tries++;
        end while (occupied.exists({nx, ny}) && tries < 8);
        x = nx;
        y = ny;
      end
      occupied[{x, y}] = 1'b1;
      add_residue(x, y, draw_h(hp));
    end
  endtask

  // boustrophedon fill of a strip, dense in contacts
  task automatic build_snake(input int len, input int width, input int hp);
    logic [7:0] x0, y0;
    int         row, col;
    x0 = 8'($urandom_range(0, 255));
    y0 = 8'($urandom_range(0, 255));
    for (int k = 0; k < len; k++) begin
      row = k / width;
      col = k % width;
      if (row % 2 == 1)
        col = width - 1 - col;
      add_residue(x0 + 8'(col), y0 + 8'(row), draw_h(hp));
    end
  endtask

  // random sites packed in a small box: clashes and stray contacts
  task automatic build_scatter(input int len, input int span, input int hp);
    logic [7:0] x0, y0;
    x0 = 8'($urandom_range(0, 255));
    y0 = 8'($urandom_range(0, 255));
    for (int k = 0; k < len; k++)
      add_residue(x0 + 8'($urandom_range(0, span)), y0 + 8'($urandom_range(0, span)),
                  draw_h(hp));
  endtask

  task automatic send_chain();
    int gap;
    chain_q[chain_q.size() - 1].last_residue = 1'b1;
    for (int k = 0; k < chain_q.size(); k++) begin
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      start   <= 1'b1;
      in_data <= chain_q[k];
      do @(posedge clk); while (busy);
      residues_sent++;
    end
    chains_sent++;
    chain_q.delete();
  endtask

  // idle the block, let any residue scan drain, then set min_separation
  task automatic write_min_sep(input logic [3:0] sep);
    start <= 1'b0;
    @(posedge clk);
    while (scores_pending != 0) @(posedge clk);
    repeat (MAX_RESIDUES + 24) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= sep;
    @(posedge clk);
    cfg_we <= 1'b0;
    sep_writes++;
  endtask

  initial begin
    logic [3:0] sep_plan [8];
    int         phase_base;
    int         pick;
    int         hp;
    int         len;
    int         i, j;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed chains under the reset separation of 3
    steady = 1'b0;
    add_residue(8'h80, 8'h80, 1'b1);
    send_chain();
    add_residue(8'h7f, 8'h7f, 1'b1);
    add_residue(8'h7f, 8'h7f, 1'b0);
    send_chain();
    // u-turn: only the ends are far enough apart in the chain
    add_residue(8'd0, 8'd0, 1'b1);
    add_residue(8'd1, 8'd0, 1'b1);
    add_residue(8'd1, 8'd1, 1'b1);
    add_residue(8'd0, 8'd1, 1'b1);
    send_chain();
    // neighbors across the coordinate wrap are not in contact
    steady = 1'b1;
    add_residue(8'h7f, 8'd0, 1'b1);
    add_residue(8'h7f, 8'd1, 1'b0);
    add_residue(8'h80, 8'd1, 1'b0);
    add_residue(8'h80, 8'd0, 1'b1);
    send_chain();
    add_residue(8'd5, 8'h7f, 1'b1);
    add_residue(8'd6, 8'h7f, 1'b0);
    add_residue(8'd6, 8'h80, 1'b0);
    add_residue(8'd5, 8'h80, 1'b1);
    send_chain();
    steady = 1'b0;
    build_snake(6, 2, 100);
    send_chain();

    sep_plan[0] = 4'd1;
    sep_plan[1] = 4'd8;
    sep_plan[2] = 4'd0;
    sep_plan[3] = 4'd15;
    sep_plan[4] = 4'd2;
    sep_plan[5] = 4'($urandom_range(0, 15));
    sep_plan[6] = 4'd3;
    sep_plan[7] = 4'd5;

    for (int p = 0; p < 8; p++) begin
      write_min_sep(sep_plan[p]);
      phase_base = residues_sent;
      if (p == 0) begin
        // overflow with the closing residue itself dropped
        steady = 1'b0;
        build_snake(MAX_RESIDUES + 2, 8, 70);
        send_chain();
      end
      while (residues_sent - phase_base < PHASE_ITEMS) begin
        steady = ($urandom_range(0, 3) == 0);
        hp     = $urandom_range(20, 100);
        pick   = $urandom_range(0, 99);
        if (pick < 40) begin
          build_walk($urandom_range(0, 9) == 0 ? $urandom_range(17, 40)
                                               : $urandom_range(1, 16), hp);
        end else if (pick < 65) begin
          build_snake($urandom_range(2, 24), $urandom_range(2, 6), hp);
        end else if (pick < 75) begin
          build_scatter($urandom_range(1, 12), $urandom_range(1, 4), hp);
        end else if (pick < 85) begin
          // force a shared site into an otherwise mostly self-avoiding walk
          len = $urandom_range(2, 16);
          build_walk(len, hp);
          i = $urandom_range(0, len - 2);
          j = $urandom_range(i + 1, len - 1);
          chain_q[j].x_coord = chain_q[i].x_coord;
          chain_q[j].y_coord = chain_q[i].y_coord;
        end else if (pick < 92) begin
          len = $urandom_range(1, 3);
          for (int k = 0; k < len; k++)
            add_residue($urandom_range(0, 1) ? 8'h80 : 8'h7f,
                        $urandom_range(0, 1) ? 8'h80 : 8'h7f, draw_h(hp));
        end else if ($urandom_range(0, 2) == 0) begin
          build_snake($urandom_range(MAX_RESIDUES + 1, MAX_RESIDUES + 6),
                      $urandom_range(4, 8), hp);
        end else if ($urandom_range(0, 1) == 0) begin
          build_snake($urandom_range(40, MAX_RESIDUES), $urandom_range(3, 8), hp);
        end else begin
          build_walk($urandom_range(40, MAX_RESIDUES), hp);
        end
        send_chain();
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (scores_pending != 0) @(posedge clk);
    repeat (MAX_RESIDUES + 24) @(posedge clk);

    $display("%0d residues in %0d chains, %0d scores checked, %0d separation writes",
             residues_sent, chains_sent, scores_checked, sep_writes);
    $display("%0d mismatches over %0d cycles", fail_count, cycles);
    if (fail_count == 0 && scores_pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
